>>> sv/fdd_pkg.sv
package fdd_pkg;

    // Sample format: signed fixed point, FRAC_BITS fraction bits
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Divider sizing: quotient bits formed one per cycle, scaled dividend width
    localparam int QUOT_W = DATA_WIDTH + 1;
    localparam int NUM_W  = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Configuration port
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_ONLY   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISCRETE_MODE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAD_MODE      = 2'd2;

    // Discrete padding codes
    localparam logic [1:0] PAD_MID   = 2'd0;
    localparam logic [1:0] PAD_LEAD  = 2'd1;
    localparam logic [1:0] PAD_TRAIL = 2'd2;
    localparam logic [1:0] PAD_BOTH  = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic        [DATA_WIDTH-1:0] t_mag;
    typedef logic        [QUOT_W-1:0]     t_quot;

    localparam t_data DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

endpackage

>>> sv/finite_difference_derivative.sv
// A derived sample passes through S_DIV and S_FIN before its results appear in S_EMIT;
// the restoring divider forms one of the DATA_WIDTH+1 slope quotient bits per cycle.
// A derived sample gives 1 to 3 results, and no new sample is taken until its last result is taken;
// a sample-only echo gives one result, a first point of a list none.
// Reset: synchronous, active low; clears the sequencer, the stored point and the point
// count, and sets sample_only 0, discrete_mode 0, pad_mode 2.
module finite_difference_derivative import fdd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample channel
    input  logic              i_valid,
    output logic              o_ready,
    input  t_data             i_sample_x,
    input  t_data             i_sample_y,
    input  logic              i_last_sample,
    // breakpoint channel
    output logic              o_valid,
    input  logic              i_ready,
    output t_data             o_point_x,
    output t_data             o_point_y,
    output logic              o_zero_step,
    output logic              o_run_last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_idx;
    logic [1:0]       r_last_idx;

    logic             r_sample_only;
    logic             r_discrete_mode;
    logic [1:0]       r_pad_mode;

    t_data            r_prev_x, r_prev_y;
    logic [1:0]       r_seen;

    t_mag             r_rem, r_dx;
    t_quot            r_nq;
    logic             r_ovf, r_dx_zero, r_dy_zero, r_dy_neg, r_neg;
    t_data            r_res;
    logic             r_zs;
    t_data            r_px [3];

    logic             acc_in, acc_out, cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT);
    assign acc_in  = i_valid && o_ready;
    assign acc_out = o_valid && i_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_SAMPLE_ONLY:   prdata = APB_DW'(r_sample_only);
            REG_DISCRETE_MODE: prdata = APB_DW'(r_discrete_mode);
            REG_PAD_MODE:      prdata = APB_DW'(r_pad_mode);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_only   <= 1'b0;
            r_discrete_mode <= 1'b0;
            r_pad_mode      <= PAD_TRAIL;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SAMPLE_ONLY:   r_sample_only   <= pwdata[0];
                REG_DISCRETE_MODE: r_discrete_mode <= pwdata[0];
                REG_PAD_MODE:      r_pad_mode      <= pwdata[1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Segment setup: differences, signs, midpoint, divider load
    // ------------------------------------------------------------------
    logic [1:0]        seen;
    logic              dx_neg_c, dy_neg_c;
    logic [DATA_WIDTH:0] dx_diff, dy_diff, mid_sum;
    t_mag              dx_abs, dy_abs, rem_init;
    logic [NUM_W-1:0]  num_c;
    t_data             mid_x, main_x;
    logic              lead, trail;

    assign seen     = (r_seen == 2'd3) ? 2'd2 : r_seen;
    assign dx_neg_c = i_sample_x < r_prev_x;
    assign dy_neg_c = i_sample_y < r_prev_y;

    assign dx_diff = dx_neg_c ? ({r_prev_x[DATA_WIDTH-1], r_prev_x}
                                 - {i_sample_x[DATA_WIDTH-1], i_sample_x})
                              : ({i_sample_x[DATA_WIDTH-1], i_sample_x}
                                 - {r_prev_x[DATA_WIDTH-1], r_prev_x});
    assign dy_diff = dy_neg_c ? ({r_prev_y[DATA_WIDTH-1], r_prev_y}
                                 - {i_sample_y[DATA_WIDTH-1], i_sample_y})
                              : ({i_sample_y[DATA_WIDTH-1], i_sample_y}
                                 - {r_prev_y[DATA_WIDTH-1], r_prev_y});
    assign dx_abs = dx_diff[DATA_WIDTH-1:0];
    assign dy_abs = dy_diff[DATA_WIDTH-1:0];

    // Scaled dividend dy * 2^FRAC_BITS; its top bits preload the remainder
    assign num_c    = NUM_W'(dy_abs) << FRAC_BITS;
    assign rem_init = DATA_WIDTH'(num_c >> QUOT_W);

    // Floor of the mean, exact in one extra bit
    assign mid_sum = {r_prev_x[DATA_WIDTH-1], r_prev_x}
                   + {i_sample_x[DATA_WIDTH-1], i_sample_x};
    assign mid_x   = mid_sum[DATA_WIDTH:1];

    // Breakpoint placement for discrete mode
    assign lead  = r_discrete_mode && (seen == 2'd1)
                   && ((r_pad_mode == PAD_LEAD) || (r_pad_mode == PAD_BOTH));
    assign trail = !r_discrete_mode || (i_last_sample
                   && ((r_pad_mode == PAD_TRAIL) || (r_pad_mode == PAD_BOTH)));

    always_comb begin
        if (!r_discrete_mode) begin
            main_x = r_prev_x;
        end else begin
            case (r_pad_mode)
                PAD_LEAD:  main_x = i_sample_x;
                PAD_TRAIL: main_x = r_prev_x;
                default:   main_x = mid_x;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Divider step: one restoring quotient bit per cycle
    // ------------------------------------------------------------------
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH+1:0] sub;
    logic                  qbit;
    t_mag                  rem_next;

    assign trial    = {r_rem, r_nq[QUOT_W-1]};
    assign sub      = {1'b0, trial} - {2'b00, r_dx};
    assign qbit     = !sub[DATA_WIDTH+1];
    assign rem_next = qbit ? sub[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Slope sign and saturation
    // ------------------------------------------------------------------
    t_quot lim_pos, lim_neg;
    t_data slope;

    assign lim_pos = QUOT_W'(t_mag'(DATA_MAX));
    assign lim_neg = QUOT_W'(t_mag'(DATA_MIN));

    always_comb begin
        if (r_dy_zero) begin
            slope = '0;
        end else if (r_dx_zero) begin
            slope = r_dy_neg ? DATA_MIN : DATA_MAX;
        end else if (r_neg) begin
            slope = (r_ovf || (r_nq > lim_neg)) ? DATA_MIN
                  : t_data'(t_mag'(0) - r_nq[DATA_WIDTH-1:0]);
        end else begin
            slope = (r_ovf || (r_nq > lim_pos)) ? DATA_MAX
                  : t_data'(r_nq[DATA_WIDTH-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (r_sample_only) begin
                        n_state = S_EMIT;
                    end else if (seen != 2'd0) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_EMIT;
            S_EMIT: begin
                if (acc_out && (r_idx == r_last_idx)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, stored point and point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_seen   <= '0;
        end else begin
            r_state <= n_state;
            if (acc_in) begin
                r_cnt    <= '0;
                r_idx    <= '0;
                r_prev_x <= i_sample_x;
                r_prev_y <= i_sample_y;
                r_seen   <= i_last_sample ? 2'd0 : ((seen == 2'd2) ? 2'd2 : seen + 2'd1);
            end else begin
                if (r_state == S_DIV) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (acc_out) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Datapath registers: divider, result and breakpoint list
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_dx      <= dx_abs;
            r_rem     <= rem_init;
            r_nq      <= QUOT_W'(num_c);
            r_ovf     <= rem_init >= dx_abs;
            r_dx_zero <= (dx_abs == '0);
            r_dy_zero <= (dy_abs == '0);
            r_dy_neg  <= dy_neg_c;
            r_neg     <= dy_neg_c != dx_neg_c;
            if (r_sample_only) begin
                r_px[0]    <= i_sample_x;
                r_px[1]    <= i_sample_x;
                r_px[2]    <= i_sample_x;
                r_last_idx <= 2'd0;
                r_res      <= i_sample_y;
                r_zs       <= 1'b0;
            end else begin
                r_px[0]    <= lead ? r_prev_x : main_x;
                r_px[1]    <= lead ? main_x : i_sample_x;
                r_px[2]    <= i_sample_x;
                r_last_idx <= 2'(lead) + 2'(trail);
            end
        end else if (r_state == S_DIV) begin
            r_rem <= rem_next;
            r_nq  <= {r_nq[QUOT_W-2:0], qbit};
        end else if (r_state == S_FIN) begin
            r_res <= slope;
            r_zs  <= r_dx_zero;
        end
    end

    // ------------------------------------------------------------------
    // Result output
    // ------------------------------------------------------------------
    always_comb begin
        case (r_idx)
            2'd0:    o_point_x = r_px[0];
            2'd1:    o_point_x = r_px[1];
            default: o_point_x = r_px[2];
        endcase
    end

    assign o_point_y   = r_res;
    assign o_zero_step = r_zs;
    assign o_run_last  = (r_idx == r_last_idx);

endmodule

>>> verif/tb_top.sv
module tb_top;
    import fdd_pkg::*;

    localparam int SETTLE_CYCLES = DATA_WIDTH + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int N_PHASES      = 9;
    localparam int PHASE_ITEMS   = 24;

    typedef struct {
        t_data x;
        t_data y;
        logic  is_last;
    } t_sample;

    typedef struct {
        t_data px;
        t_data py;
        logic  zs;
        logic  rl;
    } t_breakpoint;

    // DUT signals
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    t_data             i_sample_x    = '0;
    t_data             i_sample_y    = '0;
    logic              i_last_sample = 1'b0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    t_data             o_point_x;
    t_data             o_point_y;
    logic              o_zero_step;
    logic              o_run_last;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Stimulus and expected breakpoints
    t_sample     pend_samples[$];
    t_breakpoint bp_expect[$];

    // Predictor copy of registers and stored point
    logic        cfg_sample_only = 1'b0;
    logic        cfg_discrete    = 1'b0;
    logic [1:0]  cfg_pad         = PAD_TRAIL;
    t_data       last_x          = '0;
    t_data       last_y          = '0;
    int          pts_seen        = 0;

    // Idle control
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    logic        rx_hold         = 1'b0;
    event        hold_ev;
    logic        run_done        = 1'b0;

    // Counters
    int          n_queued        = 0;
    int          n_accepted      = 0;
    int          n_checked       = 0;
    int          n_zero_seen     = 0;
    int          n_writes        = 0;
    int          n_errors        = 0;

    // Register settings per phase
    logic        so_tab[N_PHASES]  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    logic        dm_tab[N_PHASES]  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [1:0]  pad_tab[N_PHASES] = '{PAD_BOTH, PAD_MID, PAD_TRAIL, PAD_LEAD, PAD_MID,
                                       PAD_TRAIL, PAD_BOTH, PAD_BOTH, PAD_LEAD};

    finite_difference_derivative u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_zero_step   (o_zero_step),
        .o_run_last    (o_run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Slope dy * 2^FRAC_BITS / dx, truncated toward zero and saturated;
    // zero dx gives the signed extreme that matches the sign of dy, or zero for zero dy
    function automatic t_data segment_slope(t_data x0, t_data y0, t_data x1, t_data y1,
                                            output logic zero_dx);
        longint dx;
        longint dy;
        longint q;
        dx = longint'(x1) - longint'(x0);
        dy = longint'(y1) - longint'(y0);
        zero_dx = (dx == 0);
        if (dx == 0)
            return (dy > 0) ? DATA_MAX : ((dy < 0) ? DATA_MIN : t_data'(0));
        q = (dy <<< FRAC_BITS) / dx;
        if (q > longint'(DATA_MAX))
            return DATA_MAX;
        if (q < longint'(DATA_MIN))
            return DATA_MIN;
        return t_data'(q);
    endfunction

    // Work out the breakpoints one accepted sample causes, then store the point
    function automatic void derive_breakpoints(t_sample s);
        t_data  k;
        t_data  mid;
        logic   z;
        longint sum;
        int     n0;
        n0 = bp_expect.size();
        if (cfg_sample_only) begin
            bp_expect.push_back('{s.x, s.y, 1'b0, 1'b0});
        end else if (pts_seen != 0) begin
            k   = segment_slope(last_x, last_y, s.x, s.y, z);
            sum = longint'(last_x) + longint'(s.x);
            mid = t_data'(sum >>> 1);
            if (cfg_discrete) begin
                // lead pad on the first segment of a list
                if (pts_seen == 1 && (cfg_pad == PAD_LEAD || cfg_pad == PAD_BOTH))
                    bp_expect.push_back('{last_x, k, z, 1'b0});
                case (cfg_pad)
                    PAD_LEAD:  bp_expect.push_back('{s.x, k, z, 1'b0});
                    PAD_TRAIL: bp_expect.push_back('{last_x, k, z, 1'b0});
                    default:   bp_expect.push_back('{mid, k, z, 1'b0});
                endcase
                // trailing pad on the segment that ends the list
                if (s.is_last && (cfg_pad == PAD_TRAIL || cfg_pad == PAD_BOTH))
                    bp_expect.push_back('{s.x, k, z, 1'b0});
            end else begin
                bp_expect.push_back('{last_x, k, z, 1'b0});
                bp_expect.push_back('{s.x, k, z, 1'b0});
            end
        end
        if (bp_expect.size() > n0)
            bp_expect[$].rl = 1'b1;
        last_x   = s.x;
        last_y   = s.y;
        pts_seen = s.is_last ? 0 : ((pts_seen >= 2) ? 2 : pts_seen + 1);
    endfunction

    task automatic flag_mismatch(string what, t_data got, t_data want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // Sample driver: predict on acceptance, then offer the next pending sample
    always @(posedge i_clk) begin : sample_driver
        t_sample acc;
        t_sample nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                acc = '{i_sample_x, i_sample_y, i_last_sample};
                derive_breakpoints(acc);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || o_ready) begin
                if (pend_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    nxt = pend_samples.pop_front();
                    i_valid       <= 1'b1;
                    i_sample_x    <= nxt.x;
                    i_sample_y    <= nxt.y;
                    i_last_sample <= nxt.is_last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Breakpoint monitor: compare each transaction with the oldest expectation
    always @(posedge i_clk) begin : breakpoint_monitor
        t_breakpoint e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (bp_expect.size() == 0) begin
                    flag_mismatch("unexpected breakpoint x", o_point_x, '0);
                end else begin
                    e = bp_expect.pop_front();
                    n_checked++;
                    if (e.zs)
                        n_zero_seen++;
                    if (o_point_x !== e.px)
                        flag_mismatch("point_x", o_point_x, e.px);
                    if (o_point_y !== e.py)
                        flag_mismatch("point_y", o_point_y, e.py);
                    if (o_zero_step !== e.zs)
                        flag_mismatch("zero_step", t_data'(o_zero_step), t_data'(e.zs));
                    if (o_run_last !== e.rl)
                        flag_mismatch("run_last", t_data'(o_run_last), t_data'(e.rl));
                end
            end
            i_ready <= !rx_hold && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off so the block backs up into its input
    always begin
        @(hold_ev);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (!run_done && quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        if (!run_done) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAIL finite_difference_derivative");
            $finish;
        end
    end

    task automatic queue_sample(t_data x, t_data y, logic is_last);
        pend_samples.push_back('{x, y, is_last});
        n_queued++;
    endtask

    // Wait until every sample is taken and every breakpoint has come, then settle
    task automatic wait_drained();
        while (n_accepted != n_queued || bp_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SAMPLE_ONLY:   cfg_sample_only = val[0];
            REG_DISCRETE_MODE: cfg_discrete    = val[0];
            REG_PAD_MODE:      cfg_pad         = val[1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    // Mostly well-formed lists with random content; some noise, flat and
    // unterminated runs
    task automatic queue_random(int count);
        int    left;
        int    len;
        int    kind;
        t_data x;
        t_data y;
        t_data stride;
        logic  lst;
        left = count;
        while (left > 0) begin
            len = $urandom_range(6, 1);
            if (len > left)
                len = left;
            kind = $urandom_range(9, 0);
            x = t_data'($urandom) >>> $urandom_range(16, 0);
            y = t_data'($urandom);
            for (int i = 0; i < len; i++) begin
                lst = (i == len - 1) && (kind != 9);
                if (kind == 7)
                    queue_sample(t_data'($urandom), t_data'($urandom), 1'($urandom));
                else
                    queue_sample(x, y, lst);
                stride = t_data'($urandom >> $urandom_range(31, 8));
                if (kind == 6)
                    x = x - stride;
                else if (kind != 8)
                    x = x + stride;
                if ($urandom_range(1, 0) == 1)
                    y = t_data'($urandom);
                else
                    y = y + (t_data'($urandom) >>> $urandom_range(31, 8));
            end
            left -= len;
        end
    endtask

    initial begin : sequencer
        send_idle_pct = 31;
        recv_idle_pct = 62;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset settings (continuous output)
        queue_sample(32'sh0000_0000, 32'sh0000_0000, 1'b1);   // last sample as first point
        queue_sample(32'sh0001_0000, 32'sh0002_0000, 1'b0);   // first point, no result
        queue_sample(32'sh0003_0000, 32'sh0006_0000, 1'b0);   // slope 2.0
        queue_sample(32'sh0003_0000, DATA_MAX, 1'b0);         // zero dx, rising
        queue_sample(32'sh0003_0000, DATA_MIN, 1'b0);         // zero dx, falling
        queue_sample(32'sh0003_0000, DATA_MIN, 1'b0);         // zero dx, flat
        queue_sample(32'sh0003_0001, DATA_MAX, 1'b0);         // saturate high
        queue_sample(32'sh0003_0002, DATA_MIN, 1'b0);         // saturate low
        queue_sample(32'sh0010_0000, DATA_MIN, 1'b0);         // flat segment
        queue_sample(DATA_MAX, 32'sh0000_0000, 1'b0);
        queue_sample(DATA_MIN, DATA_MAX, 1'b0);
        queue_sample(DATA_MAX, DATA_MIN, 1'b1);
        queue_sample(DATA_MIN, DATA_MIN, 1'b0);
        queue_sample(-32'sd1, -32'sd1, 1'b0);
        queue_sample(32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
        queue_sample(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
        queue_sample(32'sh0000_8000, 32'sh0001_0000, 1'b0);
        queue_sample(32'sh0000_8001, 32'sh0000_0001, 1'b1);
        wait_drained();

        // Random phases over the register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 62;
            end else if (ph < 6) begin
                send_idle_pct = 62;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_SAMPLE_ONLY, APB_DW'(so_tab[ph]));
            write_reg(REG_DISCRETE_MODE, APB_DW'(dm_tab[ph]));
            write_reg(REG_PAD_MODE, APB_DW'(pad_tab[ph]));
            if (ph == 5) begin
                // pause the sender until everything has come out
                queue_random(PHASE_ITEMS / 2);
                wait_drained();
                queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                queue_random(PHASE_ITEMS);
                if (ph == 4)
                    -> hold_ev;
            end
            wait_drained();
        end

        run_done = 1'b1;
        if (bp_expect.size() != 0)
            flag_mismatch("breakpoints never emitted", '0, t_data'(bp_expect.size()));
        $display("run: %0d samples, %0d breakpoints checked (%0d with zero dx)",
                 n_accepted, n_checked, n_zero_seen);
        $display("run: %0d register writes over %0d settings, %0d mismatches",
                 n_writes, N_PHASES + 1, n_errors);
        if (n_errors == 0) begin
            $display("PASS finite_difference_derivative");
        end else begin
            $display("FAIL finite_difference_derivative");
        end
        $finish;
    end

endmodule
